>>> rtl/core/vector_list_beam_sequencer_unit_assert.svh
// ----------------------------------------------------------------------------
// vector list beam sequencer assertion macros
// concurrent checks on clk_i with reset rst_ni, removed for synthesis
// ----------------------------------------------------------------------------
`ifndef VECTOR_LIST_BEAM_SEQUENCER_UNIT_ASSERT_SVH
`define VECTOR_LIST_BEAM_SEQUENCER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define VLBS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define VLBS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define VLBS_ASSERT_IMP(lbl, ante, cons, msg)
`define VLBS_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

>>> rtl/core/vlbs_pkg.sv
// ----------------------------------------------------------------------------
// vlbs_pkg
// shared constants and types of the vector list beam sequencer
// ----------------------------------------------------------------------------
package vlbs_pkg;

  localparam int unsigned ModeWidth  = 8;
  localparam int unsigned ScaleWidth = 8;
  localparam int unsigned CmdWidth   = 2;

  // entry mode that closes a list
  localparam logic [ModeWidth-1:0] ModeEnd = 8'h02;

  // beam command codes
  localparam logic [CmdWidth-1:0] CmdStart = 2'd0;
  localparam logic [CmdWidth-1:0] CmdMove  = 2'd1;
  localparam logic [CmdWidth-1:0] CmdDraw  = 2'd2;
  localparam logic [CmdWidth-1:0] CmdDone  = 2'd3;

  // list phase
  localparam logic PhaseIdle = 1'b0;
  localparam logic PhaseList = 1'b1;

  typedef struct packed {
    logic                valid;
    logic [CmdWidth-1:0] cmd;
    logic                last;
    logic                phase_next;
  } dec_ctrl_t;

endpackage

>>> rtl/core/vlbs_decode.sv
// ----------------------------------------------------------------------------
// vlbs_decode
// picks the beam command that a held entry gives in its first or second slot
// ----------------------------------------------------------------------------
module vlbs_decode #(
  parameter int unsigned COORD_WIDTH = 8
) (
  input  logic signed [vlbs_pkg::ModeWidth-1:0]  mode_i,
  input  logic signed [COORD_WIDTH-1:0]          dy_i,
  input  logic signed [COORD_WIDTH-1:0]          dx_i,
  input  logic                                   list_start_i,
  input  logic signed [COORD_WIDTH-1:0]          start_y_i,
  input  logic signed [COORD_WIDTH-1:0]          start_x_i,
  input  logic        [vlbs_pkg::ScaleWidth-1:0] move_scale_i,
  input  logic        [vlbs_pkg::ScaleWidth-1:0] list_scale_i,
  input  logic                                   second_i,
  input  logic                                   phase_i,
  input  logic signed [COORD_WIDTH-1:0]          saved_y_i,
  input  logic signed [COORD_WIDTH-1:0]          saved_x_i,
  input  logic        [vlbs_pkg::ScaleWidth-1:0] saved_move_scale_i,
  input  logic        [vlbs_pkg::ScaleWidth-1:0] saved_list_scale_i,
  output vlbs_pkg::dec_ctrl_t                    ctrl_o,
  output logic signed [COORD_WIDTH-1:0]          beam_y_o,
  output logic signed [COORD_WIDTH-1:0]          beam_x_o,
  output logic        [vlbs_pkg::ScaleWidth-1:0] scale_o
);
  import vlbs_pkg::*;

  logic                  has_off;
  logic                  in_list;
  logic                  mode_zero;
  logic                  mode_end;
  logic                  is_open;
  logic signed [COORD_WIDTH-1:0] eff_y;
  logic signed [COORD_WIDTH-1:0] eff_x;
  logic [ScaleWidth-1:0] eff_ms;
  logic [ScaleWidth-1:0] eff_ls;

  assign has_off   = (dy_i != '0) || (dx_i != '0);
  assign in_list   = (phase_i == PhaseList);
  assign mode_zero = (mode_i == '0);
  assign mode_end  = (mode_i == ModeEnd);

  // a new list takes its start fields straight from the entry
  assign eff_y  = list_start_i ? start_y_i    : saved_y_i;
  assign eff_x  = list_start_i ? start_x_i    : saved_x_i;
  assign eff_ms = list_start_i ? move_scale_i : saved_move_scale_i;
  assign eff_ls = list_start_i ? list_scale_i : saved_list_scale_i;

  // resync: any positive mode other than end
  assign is_open = list_start_i || (in_list && !mode_i[ModeWidth-1] && !mode_zero && !mode_end);

  always_comb begin
    ctrl_o.valid      = 1'b0;
    ctrl_o.cmd        = CmdDone;
    ctrl_o.last       = 1'b1;
    ctrl_o.phase_next = phase_i;
    beam_y_o          = '0;
    beam_x_o          = '0;
    scale_o           = '0;
    if (list_start_i) begin
      ctrl_o.phase_next = PhaseList;
    end
    if (is_open) begin
      ctrl_o.valid = 1'b1;
      if (!second_i) begin
        ctrl_o.cmd  = CmdStart;
        ctrl_o.last = !has_off;
        beam_y_o    = eff_y;
        beam_x_o    = eff_x;
        scale_o     = eff_ms;
      end else begin
        ctrl_o.cmd  = CmdMove;
        beam_y_o    = dy_i;
        beam_x_o    = dx_i;
        scale_o     = eff_ls;
      end
    end else if (in_list) begin
      if (mode_i[ModeWidth-1]) begin
        ctrl_o.valid = 1'b1;
        ctrl_o.cmd   = CmdDraw;
        beam_y_o     = dy_i;
        beam_x_o     = dx_i;
        scale_o      = eff_ls;
      end else if (mode_zero) begin
        ctrl_o.valid = has_off;
        ctrl_o.cmd   = CmdMove;
        beam_y_o     = dy_i;
        beam_x_o     = dx_i;
        scale_o      = eff_ls;
      end else begin
        // end of list
        ctrl_o.valid      = 1'b1;
        ctrl_o.cmd        = CmdDone;
        ctrl_o.phase_next = PhaseIdle;
      end
    end
  end

endmodule

>>> rtl/core/vector_list_beam_sequencer_unit.sv
// ----------------------------------------------------------------------------
// vector_list_beam_sequencer_unit
// turns vector list entries into zero/start, move, draw and done beam commands
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) takes one list entry per request.
//   An entry with list_start_i set opens a list and latches start position
//   and both scales; it gives a go-to-start command and, for a nonzero
//   offset, a blanked move. Inside a list a negative mode draws, mode zero
//   moves (nothing for a zero offset), mode two ends the list, other positive
//   modes resync. Entries outside a list give no command.
//   Output channel (out_valid_o / out_stall_i) carries one command per
//   request; last_of_run_o marks the last command of an entry.
//   Entries pass the input register, then the output register. Throughput:
//   one entry per cycle for entries with one command or none while the
//   receiver does not stall; an entry with two holds the input until the
//   single output register, taking one command per cycle, has both.
//   Reset clears both registers and returns to the idle phase with zero
//   start fields. A stalled receiver holds the output register; a held
//   entry with a command then waits and in_stall_o rises in the same cycle.
// ----------------------------------------------------------------------------
module vector_list_beam_sequencer_unit #(
  parameter int unsigned COORD_WIDTH = 8
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic signed [vlbs_pkg::ModeWidth-1:0]  entry_mode_i,
  input  logic signed [COORD_WIDTH-1:0]          entry_dy_i,
  input  logic signed [COORD_WIDTH-1:0]          entry_dx_i,
  input  logic                                   list_start_i,
  input  logic signed [COORD_WIDTH-1:0]          start_y_i,
  input  logic signed [COORD_WIDTH-1:0]          start_x_i,
  input  logic        [vlbs_pkg::ScaleWidth-1:0] move_scale_i,
  input  logic        [vlbs_pkg::ScaleWidth-1:0] list_scale_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic        [vlbs_pkg::CmdWidth-1:0]   command_o,
  output logic signed [COORD_WIDTH-1:0]          beam_y_o,
  output logic signed [COORD_WIDTH-1:0]          beam_x_o,
  output logic        [vlbs_pkg::ScaleWidth-1:0] scale_o,
  output logic                                   last_of_run_o
);
  import vlbs_pkg::*;

  `include "vector_list_beam_sequencer_unit_assert.svh"

  // held entry
  logic                          item_vld_q;
  logic signed [ModeWidth-1:0]   mode_q;
  logic signed [COORD_WIDTH-1:0] dy_q;
  logic signed [COORD_WIDTH-1:0] dx_q;
  logic                          start_q;
  logic signed [COORD_WIDTH-1:0] sy_q;
  logic signed [COORD_WIDTH-1:0] sx_q;
  logic [ScaleWidth-1:0]         ms_q;
  logic [ScaleWidth-1:0]         ls_q;
  logic                          second_q;

  // list state
  logic                          phase_q;
  logic signed [COORD_WIDTH-1:0] saved_y_q;
  logic signed [COORD_WIDTH-1:0] saved_x_q;
  logic [ScaleWidth-1:0]         saved_ms_q;
  logic [ScaleWidth-1:0]         saved_ls_q;

  // result register
  logic                          out_vld_q;
  logic [CmdWidth-1:0]           cmd_q;
  logic signed [COORD_WIDTH-1:0] y_q;
  logic signed [COORD_WIDTH-1:0] x_q;
  logic [ScaleWidth-1:0]         sc_q;
  logic                          last_q;

  dec_ctrl_t                     ctrl;
  logic signed [COORD_WIDTH-1:0] dec_y;
  logic signed [COORD_WIDTH-1:0] dec_x;
  logic [ScaleWidth-1:0]         dec_sc;

  logic out_load;
  logic issue;
  logic item_done;
  logic in_acc;

  vlbs_decode #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_decode (
    .mode_i            (mode_q),
    .dy_i              (dy_q),
    .dx_i              (dx_q),
    .list_start_i      (start_q),
    .start_y_i         (sy_q),
    .start_x_i         (sx_q),
    .move_scale_i      (ms_q),
    .list_scale_i      (ls_q),
    .second_i          (second_q),
    .phase_i           (phase_q),
    .saved_y_i         (saved_y_q),
    .saved_x_i         (saved_x_q),
    .saved_move_scale_i(saved_ms_q),
    .saved_list_scale_i(saved_ls_q),
    .ctrl_o            (ctrl),
    .beam_y_o          (dec_y),
    .beam_x_o          (dec_x),
    .scale_o           (dec_sc)
  );

  assign out_load   = !out_vld_q || !out_stall_i;
  assign issue      = item_vld_q && ctrl.valid && out_load;
  assign item_done  = item_vld_q && (!ctrl.valid || (out_load && ctrl.last));
  assign in_stall_o = item_vld_q && !item_done;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
      second_q   <= 1'b0;
      phase_q    <= PhaseIdle;
      saved_y_q  <= '0;
      saved_x_q  <= '0;
      saved_ms_q <= '0;
      saved_ls_q <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      if (in_acc) begin
        item_vld_q <= 1'b1;
      end else if (item_done) begin
        item_vld_q <= 1'b0;
      end
      if (item_done) begin
        second_q <= 1'b0;
      end else if (issue) begin
        second_q <= 1'b1;
      end
      // list state moves on once the entry has given all its commands
      if (item_done) begin
        phase_q <= ctrl.phase_next;
        if (start_q) begin
          saved_y_q  <= sy_q;
          saved_x_q  <= sx_q;
          saved_ms_q <= ms_q;
          saved_ls_q <= ls_q;
        end
      end
      if (out_load) begin
        out_vld_q <= issue;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      mode_q  <= entry_mode_i;
      dy_q    <= entry_dy_i;
      dx_q    <= entry_dx_i;
      start_q <= list_start_i;
      sy_q    <= start_y_i;
      sx_q    <= start_x_i;
      ms_q    <= move_scale_i;
      ls_q    <= list_scale_i;
    end
    if (issue) begin
      cmd_q  <= ctrl.cmd;
      y_q    <= dec_y;
      x_q    <= dec_x;
      sc_q   <= dec_sc;
      last_q <= ctrl.last;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign command_o     = cmd_q;
  assign beam_y_o      = y_q;
  assign beam_x_o      = x_q;
  assign scale_o       = sc_q;
  assign last_of_run_o = last_q;

  `VLBS_ASSERT_IMP(a_second_held, second_q, item_vld_q, "second slot without a held entry")
  `VLBS_ASSERT_IMP(a_second_move, item_vld_q && second_q, ctrl.cmd == CmdMove && ctrl.last, "second slot must be the closing move")
  `VLBS_ASSERT_IMP(a_done_zero, out_vld_q && cmd_q == CmdDone, y_q == '0 && x_q == '0 && sc_q == '0, "list done carries nonzero fields")
  `VLBS_ASSERT_NXT(a_open_phase, item_done && start_q, phase_q == PhaseList, "list start did not open a list")
  `VLBS_ASSERT_NXT(a_start_not_last, issue && ctrl.cmd == CmdStart && !ctrl.last, item_vld_q && second_q, "start with offset lost its move")

endmodule

>>> dv/tb_vector_list_beam_sequencer_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_vector_list_beam_sequencer_unit
// self-checking bench: a directed table of list entries, then random lists
// (open, body, end) mixed with idle noise, all fed through a bursty sender
// against a stalling receiver; every command is checked in order against the
// table's expected commands or a behavioral copy of the sequencer
// ----------------------------------------------------------------------------
module tb_vector_list_beam_sequencer_unit;
  import vlbs_pkg::*;

  localparam int unsigned CW           = 8;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned RANDOM_ITEMS = 1550;
  localparam int unsigned DRAIN_TAIL   = 8;
  localparam int unsigned DRAIN_EVERY  = 400;

  typedef struct packed {
    logic [ModeWidth-1:0]  mode;
    logic [CW-1:0]         dy;
    logic [CW-1:0]         dx;
    logic                  list_start;
    logic [CW-1:0]         start_y;
    logic [CW-1:0]         start_x;
    logic [ScaleWidth-1:0] move_scale;
    logic [ScaleWidth-1:0] list_scale;
  } entry_t;

  typedef struct packed {
    logic [CmdWidth-1:0]   command;
    logic [CW-1:0]         beam_y;
    logic [CW-1:0]         beam_x;
    logic [ScaleWidth-1:0] scale;
    logic                  last;
  } beam_cmd_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [ModeWidth-1:0]  entry_mode;
  logic [CW-1:0]         entry_dy;
  logic [CW-1:0]         entry_dx;
  logic                  list_start;
  logic [CW-1:0]         start_y;
  logic [CW-1:0]         start_x;
  logic [ScaleWidth-1:0] move_scale;
  logic [ScaleWidth-1:0] list_scale;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [CmdWidth-1:0]   command;
  logic [CW-1:0]         beam_y;
  logic [CW-1:0]         beam_x;
  logic [ScaleWidth-1:0] scale;
  logic                  last_of_run;

  vector_list_beam_sequencer_unit #(
    .COORD_WIDTH(CW)
  ) uut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .entry_mode_i (entry_mode),
    .entry_dy_i   (entry_dy),
    .entry_dx_i   (entry_dx),
    .list_start_i (list_start),
    .start_y_i    (start_y),
    .start_x_i    (start_x),
    .move_scale_i (move_scale),
    .list_scale_i (list_scale),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .command_o    (command),
    .beam_y_o     (beam_y),
    .beam_x_o     (beam_x),
    .scale_o      (scale),
    .last_of_run_o(last_of_run)
  );

  // sequencer copy: list phase and latched start fields
  logic                  list_phase     = PhaseIdle;
  logic [CW-1:0]         org_y          = '0;
  logic [CW-1:0]         org_x          = '0;
  logic [ScaleWidth-1:0] org_move_scale = '0;
  logic [ScaleWidth-1:0] org_list_scale = '0;

  beam_cmd_t   beam_q[$];
  beam_cmd_t   got_cmd;
  beam_cmd_t   want_cmd;
  int unsigned errors     = 0;
  int unsigned cycle_cnt  = 0;
  int unsigned counted    = 0;
  int unsigned burst_left = 0;
  int unsigned stall_hold = 0;
  int unsigned stall_style = 0;

  entry_t    dir_entry[$];
  int        dir_n[$];
  beam_cmd_t dir_a[$];
  beam_cmd_t dir_b[$];

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // receiver stall pattern: a style held for a random number of cycles
  always @(posedge clk) begin
    if (stall_hold == 0) begin
      stall_style <= $urandom_range(0, 3);
      stall_hold  <= $urandom_range(50, 300);
    end else begin
      stall_hold <= stall_hold - 1;
    end
    case (stall_style)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 7) == 0);
      2: out_stall <= ($urandom_range(0, 1) == 0);
      default: out_stall <= ((cycle_cnt % 9) < 4);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      got_cmd = {command, beam_y, beam_x, scale, last_of_run};
      if (beam_q.size() == 0) begin
        $display("%0t: unexpected command: cmd %0d y %h x %h scale %h last %b",
                 $realtime, command, beam_y, beam_x, scale, last_of_run);
        errors++;
      end else begin
        want_cmd = beam_q.pop_front();
        if (got_cmd !== want_cmd) begin
          $display("%0t: mismatch expected cmd %0d y %h x %h scale %h last %b",
                   $realtime, want_cmd.command, want_cmd.beam_y, want_cmd.beam_x,
                   want_cmd.scale, want_cmd.last);
          $display("%0t:          actual   cmd %0d y %h x %h scale %h last %b",
                   $realtime, command, beam_y, beam_x, scale, last_of_run);
          errors++;
        end
      end
    end
  end

  function automatic beam_cmd_t mk_cmd(logic [CmdWidth-1:0] c, logic [CW-1:0] y,
                                       logic [CW-1:0] x, logic [ScaleWidth-1:0] s,
                                       logic l);
    return {c, y, x, s, l};
  endfunction

  function automatic entry_t mk_entry(logic [7:0] mode, logic [7:0] dy, logic [7:0] dx,
                                      logic st, logic [7:0] sy, logic [7:0] sx,
                                      logic [7:0] ms, logic [7:0] ls);
    return {mode, dy, dx, st, sy, sx, ms, ls};
  endfunction

  // n < 0: commands come from the sequencer copy
  function automatic void add_row(entry_t e, int n, beam_cmd_t a, beam_cmd_t b);
    dir_entry.push_back(e);
    dir_n.push_back(n);
    dir_a.push_back(a);
    dir_b.push_back(b);
  endfunction

  function automatic logic [7:0] rand_field();
    case ($urandom_range(0, 9))
      0: return 8'h00;
      1: return 8'h7f;
      2: return 8'h80;
      3: return 8'hff;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic entry_t rand_entry(logic [7:0] mode, logic st);
    entry_t e;
    e = {mode, rand_field(), rand_field(), st, rand_field(), rand_field(),
         rand_field(), rand_field()};
    if ($urandom_range(0, 7) == 0) begin
      e.dy = '0;
      e.dx = '0;
    end
    return e;
  endfunction

  function automatic logic [7:0] body_mode();
    int unsigned r;
    logic [7:0]  m;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      m = {1'b1, 7'($urandom_range(0, 127))};
    end else if (r < 75) begin
      m = 8'h00;
    end else if (r < 92) begin
      // resync: any positive mode other than the end code
      m = 8'($urandom_range(1, 127));
      if (m == ModeEnd) m = 8'h01;
    end else begin
      m = ModeEnd;
    end
    return m;
  endfunction

  // go to start, then a blanked move when the offset is nonzero
  task automatic open_list(input logic [CW-1:0] dy, input logic [CW-1:0] dx,
                           output int n, output beam_cmd_t c0, output beam_cmd_t c1);
    logic moved;
    moved = (dy != '0) || (dx != '0);
    c0 = {CmdStart, org_y, org_x, org_move_scale, !moved};
    c1 = {CmdMove, dy, dx, org_list_scale, 1'b1};
    n = moved ? 2 : 1;
  endtask

  task automatic sequence_entry(input entry_t e, output int n,
                                output beam_cmd_t c0, output beam_cmd_t c1);
    n  = 0;
    c0 = '0;
    c1 = '0;
    if (e.list_start) begin
      org_y          = e.start_y;
      org_x          = e.start_x;
      org_move_scale = e.move_scale;
      org_list_scale = e.list_scale;
      list_phase     = PhaseList;
      open_list(e.dy, e.dx, n, c0, c1);
    end else if (list_phase == PhaseList) begin
      if (e.mode[ModeWidth-1]) begin
        c0 = {CmdDraw, e.dy, e.dx, org_list_scale, 1'b1};
        n  = 1;
      end else if (e.mode == '0) begin
        if (e.dy != '0 || e.dx != '0) begin
          c0 = {CmdMove, e.dy, e.dx, org_list_scale, 1'b1};
          n  = 1;
        end
      end else if (e.mode == ModeEnd) begin
        list_phase = PhaseIdle;
        c0 = {CmdDone, {CW{1'b0}}, {CW{1'b0}}, {ScaleWidth{1'b0}}, 1'b1};
        n  = 1;
      end else begin
        open_list(e.dy, e.dx, n, c0, c1);
      end
    end
  endtask

  task automatic send_item(input entry_t e, input int n_fixed,
                           input beam_cmd_t a, input beam_cmd_t b);
    int        n;
    beam_cmd_t c0;
    beam_cmd_t c1;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 15) == 0) ? 150 : $urandom_range(1, 20);
    end
    in_valid   <= 1'b1;
    entry_mode <= e.mode;
    entry_dy   <= e.dy;
    entry_dx   <= e.dx;
    list_start <= e.list_start;
    start_y    <= e.start_y;
    start_x    <= e.start_x;
    move_scale <= e.move_scale;
    list_scale <= e.list_scale;
    do @(posedge clk); while (in_stall);
    burst_left--;
    counted++;
    sequence_entry(e, n, c0, c1);
    if (n_fixed >= 0) begin
      n  = n_fixed;
      c0 = a;
      c1 = b;
    end
    if (n > 0) beam_q.push_back(c0);
    if (n > 1) beam_q.push_back(c1);
  endtask

  task automatic drain_commands();
    in_valid <= 1'b0;
    do @(posedge clk); while (beam_q.size() != 0);
    repeat (DRAIN_TAIL) @(posedge clk);
  endtask

  initial begin
    int unsigned next_drain;
    int unsigned body_len;
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    entry_mode <= '0;
    entry_dy   <= '0;
    entry_dx   <= '0;
    list_start <= 1'b0;
    start_y    <= '0;
    start_x    <= '0;
    move_scale <= '0;
    list_scale <= '0;

    // entries while idle are ignored, start fields only latch on list_start
    add_row(mk_entry(8'hff, 8'h11, 8'h22, 1'b0, 8'h5a, 8'ha5, 8'h3c, 8'hc3), 0, '0, '0);
    add_row(mk_entry(8'h00, 8'h7f, 8'h80, 1'b0, 8'h5a, 8'ha5, 8'h3c, 8'hc3), 0, '0, '0);
    add_row(mk_entry(ModeEnd, 8'h00, 8'h00, 1'b1, 8'h7f, 8'h80, 8'hff, 8'h00), 1,
            mk_cmd(CmdStart, 8'h7f, 8'h80, 8'hff, 1'b1), '0);
    add_row(mk_entry(8'h80, 8'h7f, 8'h80, 1'b0, 8'h5a, 8'ha5, 8'h3c, 8'hc3), 1,
            mk_cmd(CmdDraw, 8'h7f, 8'h80, 8'h00, 1'b1), '0);
    add_row(mk_entry(8'h00, 8'h00, 8'h00, 1'b0, 8'h5a, 8'ha5, 8'h3c, 8'hc3), 0, '0, '0);
    add_row(mk_entry(8'h00, 8'hff, 8'h00, 1'b0, 8'h5a, 8'ha5, 8'h3c, 8'hc3), 1,
            mk_cmd(CmdMove, 8'hff, 8'h00, 8'h00, 1'b1), '0);
    add_row(mk_entry(ModeEnd, 8'h33, 8'h44, 1'b0, 8'h5a, 8'ha5, 8'h3c, 8'hc3), 1,
            mk_cmd(CmdDone, 8'h00, 8'h00, 8'h00, 1'b1), '0);
    add_row(mk_entry(8'hff, 8'h01, 8'h01, 1'b0, 8'h5a, 8'ha5, 8'h3c, 8'hc3), 0, '0, '0);
    add_row(mk_entry(8'hff, 8'h05, 8'hf9, 1'b1, 8'h80, 8'h7f, 8'h00, 8'hff), 2,
            mk_cmd(CmdStart, 8'h80, 8'h7f, 8'h00, 1'b0),
            mk_cmd(CmdMove, 8'h05, 8'hf9, 8'hff, 1'b1));
    add_row(mk_entry(8'h01, 8'h00, 8'h00, 1'b0, 8'h5a, 8'ha5, 8'h3c, 8'hc3), -1, '0, '0);
    add_row(mk_entry(8'h7f, 8'h03, 8'h00, 1'b0, 8'h5a, 8'ha5, 8'h3c, 8'hc3), -1, '0, '0);
    add_row(mk_entry(8'h03, 8'h00, 8'h01, 1'b0, 8'h5a, 8'ha5, 8'h3c, 8'hc3), -1, '0, '0);
    add_row(mk_entry(8'hff, 8'h00, 8'h00, 1'b0, 8'h5a, 8'ha5, 8'h3c, 8'hc3), -1, '0, '0);
    add_row(mk_entry(8'h00, 8'h00, 8'h80, 1'b0, 8'h5a, 8'ha5, 8'h3c, 8'hc3), -1, '0, '0);
    // a new list opens in the middle of one, its mode ignored
    add_row(mk_entry(ModeEnd, 8'h80, 8'h7f, 1'b1, 8'h00, 8'h00, 8'h01, 8'h02), -1, '0, '0);
    add_row(mk_entry(8'h00, 8'h00, 8'h00, 1'b1, 8'h12, 8'h34, 8'h56, 8'h78), -1, '0, '0);
    add_row(mk_entry(8'hc0, 8'h80, 8'h80, 1'b0, 8'h5a, 8'ha5, 8'h3c, 8'hc3), -1, '0, '0);
    add_row(mk_entry(ModeEnd, 8'h00, 8'h00, 1'b0, 8'h5a, 8'ha5, 8'h3c, 8'hc3), 1,
            mk_cmd(CmdDone, 8'h00, 8'h00, 8'h00, 1'b1), '0);
    add_row(mk_entry(ModeEnd, 8'h00, 8'h00, 1'b0, 8'h5a, 8'ha5, 8'h3c, 8'hc3), 0, '0, '0);
    add_row(mk_entry(8'h05, 8'h7f, 8'h7f, 1'b0, 8'h5a, 8'ha5, 8'h3c, 8'hc3), 0, '0, '0);
    add_row(mk_entry(8'h7f, 8'h7f, 8'h7f, 1'b1, 8'h01, 8'hff, 8'h80, 8'h7f), -1, '0, '0);
    add_row(mk_entry(8'haa, 8'h55, 8'haa, 1'b0, 8'h5a, 8'ha5, 8'h3c, 8'hc3), -1, '0, '0);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < dir_entry.size(); i++) begin
      send_item(dir_entry[i], dir_n[i], dir_a[i], dir_b[i]);
    end
    // hold the sender until every command is out
    drain_commands();

    counted    = 0;
    next_drain = DRAIN_EVERY;
    while (counted < RANDOM_ITEMS) begin
      if ($urandom_range(0, 99) < 10) begin
        // noise: stray entry, mostly ignored while idle
        send_item(rand_entry(8'($urandom_range(0, 255)), 1'b0), -1, '0, '0);
      end else begin
        send_item(rand_entry(8'($urandom_range(0, 255)), 1'b1), -1, '0, '0);
        body_len = $urandom_range(0, 10);
        for (int k = 0; k < body_len; k++) begin
          send_item(rand_entry(body_mode(), $urandom_range(0, 19) == 0), -1, '0, '0);
        end
        if ($urandom_range(0, 9) != 0) begin
          send_item(rand_entry(ModeEnd, 1'b0), -1, '0, '0);
        end
      end
      if (counted >= next_drain) begin
        drain_commands();
        next_drain += DRAIN_EVERY;
      end
    end

    drain_commands();
    if (errors == 0 && beam_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
